>>> hdl/jpt_pkg.sv
// Shared types, constants and elaboration-time tables for the joystick polar tracker.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package jpt_pkg;

    // Widths and fixed-point formats.
    localparam int SAMPLE_BITS_DEF = 8;
    localparam int OUT_W           = 8;
    localparam int ANGLE_W         = 9;
    localparam int DIST_W          = 9;
    localparam int APB_DATA_W      = 32;
    localparam int PADDR_W         = 3;
    localparam int CENTRE_RESET    = 128;

    localparam int PRESHIFT    = 40;
    localparam int FRAC        = 56;
    localparam int ITER        = 48;
    localparam int ITER_W      = $clog2(ITER);
    localparam int ZW          = FRAC + 3;
    localparam int TH_W        = FRAC + 2;
    localparam int SCALE_W     = 6;
    localparam int PROD_W      = TH_W + SCALE_W;
    localparam int ANGLE_SCALE = 57;

    // Register indexes on the configuration port.
    localparam logic REG_CENTRE_X = 1'b0;
    localparam logic REG_CENTRE_Y = 1'b1;

    // How the series term shrinks from one step to the next.
    localparam logic [1:0] SHRINK_POW2  = 2'd0;
    localparam logic [1:0] SHRINK_25    = 2'd1;
    localparam logic [1:0] SHRINK_57121 = 2'd2;

    typedef logic signed [ZW-1:0] angle_t;
    typedef angle_t rot_tab_t [ITER];

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_BUSY
    } seq_state_t;

    typedef enum logic [2:0] {
        CPH_IDLE,
        CPH_RUN,
        CPH_CLAMP,
        CPH_SCALE,
        CPH_DONE
    } cordic_phase_t;

    typedef struct packed {
        logic start;
        logic dx_neg;
        logic dy_neg;
    } cordic_cmd_t;

    // Divides a series term by the odd number 2n+1.
    function automatic logic [63:0] div_odd(input logic [63:0] p, input int unsigned n);
        logic [63:0] q;
        case (n)
            0:  q = p;
            1:  q = p / 3;
            2:  q = p / 5;
            3:  q = p / 7;
            4:  q = p / 9;
            5:  q = p / 11;
            6:  q = p / 13;
            7:  q = p / 15;
            8:  q = p / 17;
            9:  q = p / 19;
            10: q = p / 21;
            11: q = p / 23;
            12: q = p / 25;
            13: q = p / 27;
            14: q = p / 29;
            15: q = p / 31;
            16: q = p / 33;
            17: q = p / 35;
            18: q = p / 37;
            19: q = p / 39;
            20: q = p / 41;
            21: q = p / 43;
            22: q = p / 45;
            23: q = p / 47;
            24: q = p / 49;
            25: q = p / 51;
            26: q = p / 53;
            27: q = p / 55;
            28: q = p / 57;
            29: q = p / 59;
            30: q = p / 61;
            31: q = p / 63;
            default: q = '0;
        endcase
        return q;
    endfunction

    function automatic logic [63:0] shrink(input logic [63:0] p, input logic [1:0] kind,
                                           input int unsigned sh);
        logic [63:0] q;
        case (kind)
            SHRINK_25:    q = p / 25;
            SHRINK_57121: q = p / 57121;
            default:      q = p >> (2 * sh);
        endcase
        return q;
    endfunction

    // Alternating series for atan(1/m) in Q56, rounded down term by term.
    function automatic logic signed [63:0] atan_series(input logic [63:0] p0,
                                                      input logic [1:0] kind,
                                                      input int unsigned sh);
        logic [63:0]        p;
        logic [63:0]        t;
        logic signed [63:0] s;
        logic               neg;
        p   = p0;
        s   = '0;
        neg = 1'b0;
        for (int unsigned n = 0; n < 32; n++)
        begin
            if (p != '0)
            begin
                t   = div_odd(p, n);
                s   = neg ? s - $signed(t) : s + $signed(t);
                neg = ~neg;
                p   = shrink(p, kind, sh);
            end
        end
        return s;
    endfunction

    function automatic logic signed [63:0] calc_pi_q();
        logic signed [63:0] a5;
        logic signed [63:0] a239;
        a5   = atan_series((64'd1 << FRAC) / 5, SHRINK_25, 0);
        a239 = atan_series((64'd1 << FRAC) / 239, SHRINK_57121, 0);
        return (a5 <<< 4) - (a239 <<< 2);
    endfunction

    localparam logic signed [63:0] PI_Q64 = calc_pi_q();

    function automatic rot_tab_t build_rot_tab();
        rot_tab_t tab;
        for (int i = 0; i < ITER; i++)
        begin
            if (i == 0)
                tab[i] = angle_t'(PI_Q64 >>> 2);
            else
                tab[i] = angle_t'(atan_series((64'd1 << FRAC) >> i, SHRINK_POW2, i));
        end
        return tab;
    endfunction

    localparam rot_tab_t ROT_TAB   = build_rot_tab();
    localparam angle_t   PI_Q      = angle_t'(PI_Q64);
    localparam angle_t   HALF_PI_Q = angle_t'(PI_Q64 >>> 1);

endpackage

`default_nettype wire

>>> hdl/jpt_cordic.sv
// Iterative CORDIC vectoring unit: one rotation step per cycle, then angle scaling.
// Depends on jpt_pkg for the rotation table, formats and phase type.
`default_nettype none

module jpt_cordic #(
    parameter int SAMPLE_BITS = jpt_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire jpt_pkg::cordic_cmd_t                cmd,
    input  wire logic [SAMPLE_BITS-1:0]              ax,
    input  wire logic [SAMPLE_BITS-1:0]              ay,
    output logic                                     done,
    output logic signed [jpt_pkg::ANGLE_W-1:0]       angle
);

    localparam int DW = SAMPLE_BITS + jpt_pkg::PRESHIFT + 3;

    jpt_pkg::cordic_phase_t phase_reg, phase_next;

    logic [jpt_pkg::ITER_W-1:0]        iter_reg, iter_next;
    logic signed [DW-1:0]              x_reg, x_next;
    logic signed [DW-1:0]              y_reg, y_next;
    jpt_pkg::angle_t                   z_reg, z_next;
    logic [jpt_pkg::TH_W-1:0]          th_reg, th_next;
    logic signed [jpt_pkg::ANGLE_W-1:0] angle_reg, angle_next;
    logic                              ax_zero_reg, ax_zero_next;
    logic                              ay_zero_reg, ay_zero_next;
    logic                              dxn_reg, dxn_next;
    logic                              dyn_reg, dyn_next;

    logic signed [DW-1:0]              xs;
    logic signed [DW-1:0]              ys;
    jpt_pkg::angle_t                   rot;
    jpt_pkg::angle_t                   phi;
    logic [jpt_pkg::PROD_W-1:0]        prod;
    logic [jpt_pkg::OUT_W-1:0]         mag;
    logic signed [jpt_pkg::ANGLE_W-1:0] mag_ext;

    // Phase sequencing.
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            jpt_pkg::CPH_IDLE, jpt_pkg::CPH_DONE:
            begin
                if (cmd.start)
                begin
                    if (ax == '0 || ay == '0)
                        phase_next = jpt_pkg::CPH_CLAMP;
                    else
                        phase_next = jpt_pkg::CPH_RUN;
                end
            end
            jpt_pkg::CPH_RUN:
            begin
                if (iter_reg == jpt_pkg::ITER_W'(jpt_pkg::ITER - 1))
                    phase_next = jpt_pkg::CPH_CLAMP;
            end
            jpt_pkg::CPH_CLAMP: phase_next = jpt_pkg::CPH_SCALE;
            jpt_pkg::CPH_SCALE: phase_next = jpt_pkg::CPH_DONE;
            default:            phase_next = jpt_pkg::CPH_IDLE;
        endcase
    end

    // Shared shift-add datapath.
    always_comb
    begin
        xs  = x_reg >>> iter_reg;
        ys  = y_reg >>> iter_reg;
        rot = jpt_pkg::ROT_TAB[iter_reg];

        if (ay_zero_reg)
            phi = '0;
        else if (ax_zero_reg)
            phi = jpt_pkg::HALF_PI_Q;
        else if (z_reg < 0)
            phi = '0;
        else if (z_reg > jpt_pkg::HALF_PI_Q)
            phi = jpt_pkg::HALF_PI_Q;
        else
            phi = z_reg;

        prod    = jpt_pkg::PROD_W'(th_reg) * jpt_pkg::PROD_W'(jpt_pkg::ANGLE_SCALE);
        mag     = prod[jpt_pkg::PROD_W-1 -: jpt_pkg::OUT_W];
        mag_ext = {1'b0, mag};

        iter_next    = iter_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        th_next      = th_reg;
        angle_next   = angle_reg;
        ax_zero_next = ax_zero_reg;
        ay_zero_next = ay_zero_reg;
        dxn_next     = dxn_reg;
        dyn_next     = dyn_reg;

        case (phase_reg)
            jpt_pkg::CPH_IDLE, jpt_pkg::CPH_DONE:
            begin
                if (cmd.start)
                begin
                    iter_next    = '0;
                    x_next       = DW'(ax) << jpt_pkg::PRESHIFT;
                    y_next       = DW'(ay) << jpt_pkg::PRESHIFT;
                    z_next       = '0;
                    ax_zero_next = (ax == '0);
                    ay_zero_next = (ay == '0);
                    dxn_next     = cmd.dx_neg;
                    dyn_next     = cmd.dy_neg;
                end
            end
            jpt_pkg::CPH_RUN:
            begin
                if (!y_reg[DW-1])
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + rot;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - rot;
                end
                if (iter_reg != jpt_pkg::ITER_W'(jpt_pkg::ITER - 1))
                    iter_next = iter_reg + 1'b1;
            end
            jpt_pkg::CPH_CLAMP:
            begin
                if (dxn_reg)
                    th_next = jpt_pkg::TH_W'(jpt_pkg::PI_Q - phi);
                else
                    th_next = jpt_pkg::TH_W'(phi);
            end
            jpt_pkg::CPH_SCALE:
            begin
                angle_next = dyn_reg ? -mag_ext : mag_ext;
            end
            default:
            begin
                iter_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= jpt_pkg::CPH_IDLE;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        iter_reg    <= iter_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        th_reg      <= th_next;
        angle_reg   <= angle_next;
        ax_zero_reg <= ax_zero_next;
        ay_zero_reg <= ay_zero_next;
        dxn_reg     <= dxn_next;
        dyn_reg     <= dyn_next;
    end

    assign done  = (phase_reg == jpt_pkg::CPH_DONE);
    assign angle = angle_reg;

endmodule

`default_nettype wire

>>> hdl/jpt_isqrt.sv
// Digit-by-digit integer square root of ax*ax + ay*ay, two radicand bits per cycle.
// Depends on jpt_pkg for the default sample width.
`default_nettype none

module jpt_isqrt #(
    parameter int SAMPLE_BITS = jpt_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [SAMPLE_BITS-1:0] ax,
    input  wire logic [SAMPLE_BITS-1:0] ay,
    output logic                        done,
    output logic [SAMPLE_BITS:0]        root
);

    localparam int SQ_W   = 2 * SAMPLE_BITS;
    localparam int VW     = SQ_W + 1;
    localparam int NSTEP  = SAMPLE_BITS + 1;
    localparam int STEP_W = $clog2(NSTEP);

    logic [VW-1:0]     rem_reg, rem_next;
    logic [VW-1:0]     res_reg, res_next;
    logic [VW-1:0]     bit_reg, bit_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;

    logic [SQ_W-1:0]   sq_x;
    logic [SQ_W-1:0]   sq_y;
    logic [VW:0]       trial;

    always_comb
    begin
        sq_x  = SQ_W'(ax) * SQ_W'(ax);
        sq_y  = SQ_W'(ay) * SQ_W'(ay);
        trial = {1'b0, res_reg} + {1'b0, bit_reg};

        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = done_reg;

        if (start)
        begin
            rem_next  = VW'(sq_x) + VW'(sq_y);
            res_next  = '0;
            bit_next  = VW'(1) << SQ_W;
            cnt_next  = '0;
            run_next  = 1'b1;
            done_next = 1'b0;
        end
        else if (run_reg)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next = rem_reg - trial[VW-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(NSTEP - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[SAMPLE_BITS:0];

endmodule

`default_nettype wire

>>> hdl/joystick_polar_tracker.sv
// Top level of the joystick polar tracker: APB register file, input and output words,
// axis extremes and the sequencer. Depends on jpt_pkg, jpt_cordic and jpt_isqrt.
//
// How to use it.
// Each input word is one converter frame (sample_x, sample_y, slider_a, slider_b),
// offered with in_valid and taken when in_valid and in_ready are both high. Each
// accepted word yields exactly one output word, offered with out_valid and taken
// when out_valid and out_ready are both high. The output word carries the four
// readings, the running minimum and maximum of each joystick axis (this frame
// included), the angle of the stick from the configured centre in units of
// 1/57 radian (truncated toward zero, signed) and the floor of its distance.
// The angle comes from a CORDIC vectoring unit that performs one rotation step per
// cycle over 48 steps. When either axis sits exactly on its centre the rotation
// steps are skipped and the nine-step square root sets the pace. in_ready is high
// only while the block is idle, so a word is taken only once the last one has left
// the units. The output register parts the two sides: a new word is taken while the
// previous result still waits, and a finished result waits inside the block until
// the output register is free.
// After reset the centres are 128, the minima all ones and the maxima zero, and no
// output word is pending. Centres are written through the APB port at byte
// addresses 0 (x) and 4 (y); a write lands at once, so it should only be made while
// the block is idle.
`default_nettype none

module joystick_polar_tracker #(
    parameter int SAMPLE_BITS = jpt_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [jpt_pkg::PADDR_W-1:0]          paddr,
    input  wire logic [jpt_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [jpt_pkg::APB_DATA_W-1:0]            prdata,
    output logic                                      pready,

    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [SAMPLE_BITS-1:0]               sample_x,
    input  wire logic [SAMPLE_BITS-1:0]               sample_y,
    input  wire logic [SAMPLE_BITS-1:0]               slider_a,
    input  wire logic [SAMPLE_BITS-1:0]               slider_b,

    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [jpt_pkg::OUT_W-1:0]                 joy_x,
    output logic [jpt_pkg::OUT_W-1:0]                 joy_y,
    output logic [jpt_pkg::OUT_W-1:0]                 slider_a_out,
    output logic [jpt_pkg::OUT_W-1:0]                 slider_b_out,
    output logic [jpt_pkg::OUT_W-1:0]                 x_min,
    output logic [jpt_pkg::OUT_W-1:0]                 x_max,
    output logic [jpt_pkg::OUT_W-1:0]                 y_min,
    output logic [jpt_pkg::OUT_W-1:0]                 y_max,
    output logic signed [jpt_pkg::ANGLE_W-1:0]        angle_deg,
    output logic [jpt_pkg::DIST_W-1:0]                distance
);

    jpt_pkg::seq_state_t state_reg, state_next;

    // Configuration and running extremes; these reset to defined values.
    logic [SAMPLE_BITS-1:0] center_x_reg, center_x_next;
    logic [SAMPLE_BITS-1:0] center_y_reg, center_y_next;
    logic [SAMPLE_BITS-1:0] x_min_reg, x_min_next;
    logic [SAMPLE_BITS-1:0] x_max_reg, x_max_next;
    logic [SAMPLE_BITS-1:0] y_min_reg, y_min_next;
    logic [SAMPLE_BITS-1:0] y_max_reg, y_max_next;
    logic                   out_valid_reg, out_valid_next;

    // The accepted frame and its deltas, held while the units work.
    logic [SAMPLE_BITS-1:0] sx_hold_reg, sx_hold_next;
    logic [SAMPLE_BITS-1:0] sy_hold_reg, sy_hold_next;
    logic [SAMPLE_BITS-1:0] sa_hold_reg, sa_hold_next;
    logic [SAMPLE_BITS-1:0] sb_hold_reg, sb_hold_next;
    logic [SAMPLE_BITS-1:0] ax_reg, ax_next;
    logic [SAMPLE_BITS-1:0] ay_reg, ay_next;
    logic                   dxn_reg, dxn_next;
    logic                   dyn_reg, dyn_next;

    // Output word register.
    logic [jpt_pkg::OUT_W-1:0]          joy_x_reg, joy_x_next;
    logic [jpt_pkg::OUT_W-1:0]          joy_y_reg, joy_y_next;
    logic [jpt_pkg::OUT_W-1:0]          sla_reg, sla_next;
    logic [jpt_pkg::OUT_W-1:0]          slb_reg, slb_next;
    logic [jpt_pkg::OUT_W-1:0]          xmin_out_reg, xmin_out_next;
    logic [jpt_pkg::OUT_W-1:0]          xmax_out_reg, xmax_out_next;
    logic [jpt_pkg::OUT_W-1:0]          ymin_out_reg, ymin_out_next;
    logic [jpt_pkg::OUT_W-1:0]          ymax_out_reg, ymax_out_next;
    logic signed [jpt_pkg::ANGLE_W-1:0] angle_reg, angle_next;
    logic [jpt_pkg::DIST_W-1:0]         dist_reg, dist_next;

    logic                               cfg_wr;
    logic                               cfg_idx;
    logic                               in_acc;
    logic                               slot_free;
    logic                               finish;
    logic                               x_below;
    logic                               y_below;
    jpt_pkg::cordic_cmd_t               cordic_cmd;
    logic                               cordic_done;
    logic signed [jpt_pkg::ANGLE_W-1:0] cordic_angle;
    logic                               sqrt_done;
    logic [SAMPLE_BITS:0]               sqrt_root;

    // APB decode: the register index is the word address bit.
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[jpt_pkg::PADDR_W-1];
    assign pready  = 1'b1;
    assign prdata  = (cfg_idx == jpt_pkg::REG_CENTRE_Y)
                   ? jpt_pkg::APB_DATA_W'(center_y_reg)
                   : jpt_pkg::APB_DATA_W'(center_x_reg);

    assign in_ready  = (state_reg == jpt_pkg::ST_IDLE);
    assign in_acc    = in_valid & in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign finish    = (state_reg == jpt_pkg::ST_BUSY) && cordic_done && sqrt_done
                       && slot_free;

    assign cordic_cmd.start  = (state_reg == jpt_pkg::ST_LAUNCH);
    assign cordic_cmd.dx_neg = dxn_reg;
    assign cordic_cmd.dy_neg = dyn_reg;

    jpt_cordic #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cordic_cmd),
        .ax    (ax_reg),
        .ay    (ay_reg),
        .done  (cordic_done),
        .angle (cordic_angle)
    );

    jpt_isqrt #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_cmd.start),
        .ax    (ax_reg),
        .ay    (ay_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // Sequencer: take a frame, launch both units, then wait for both results and a
    // free output register.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            jpt_pkg::ST_IDLE:
            begin
                if (in_acc)
                    state_next = jpt_pkg::ST_LAUNCH;
            end
            jpt_pkg::ST_LAUNCH: state_next = jpt_pkg::ST_BUSY;
            jpt_pkg::ST_BUSY:
            begin
                if (finish)
                    state_next = jpt_pkg::ST_IDLE;
            end
            default: state_next = jpt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        x_below = sample_x < center_x_reg;
        y_below = sample_y < center_y_reg;

        center_x_next  = center_x_reg;
        center_y_next  = center_y_reg;
        x_min_next     = x_min_reg;
        x_max_next     = x_max_reg;
        y_min_next     = y_min_reg;
        y_max_next     = y_max_reg;
        sx_hold_next   = sx_hold_reg;
        sy_hold_next   = sy_hold_reg;
        sa_hold_next   = sa_hold_reg;
        sb_hold_next   = sb_hold_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        dxn_next       = dxn_reg;
        dyn_next       = dyn_reg;
        joy_x_next     = joy_x_reg;
        joy_y_next     = joy_y_reg;
        sla_next       = sla_reg;
        slb_next       = slb_reg;
        xmin_out_next  = xmin_out_reg;
        xmax_out_next  = xmax_out_reg;
        ymin_out_next  = ymin_out_reg;
        ymax_out_next  = ymax_out_reg;
        angle_next     = angle_reg;
        dist_next      = dist_reg;
        out_valid_next = out_valid_reg;

        if (cfg_wr)
        begin
            if (cfg_idx == jpt_pkg::REG_CENTRE_X)
                center_x_next = pwdata[SAMPLE_BITS-1:0];
            else
                center_x_next = center_x_reg;
            if (cfg_idx == jpt_pkg::REG_CENTRE_Y)
                center_y_next = pwdata[SAMPLE_BITS-1:0];
            else
                center_y_next = center_y_reg;
        end

        // On acceptance the extremes already include this frame, and the deltas are
        // formed as a magnitude and a sign so the units never see a negative value.
        if (in_acc)
        begin
            sx_hold_next = sample_x;
            sy_hold_next = sample_y;
            sa_hold_next = slider_a;
            sb_hold_next = slider_b;
            if (sample_x < x_min_reg)
                x_min_next = sample_x;
            if (sample_x > x_max_reg)
                x_max_next = sample_x;
            if (sample_y < y_min_reg)
                y_min_next = sample_y;
            if (sample_y > y_max_reg)
                y_max_next = sample_y;
            dxn_next = x_below;
            dyn_next = y_below;
            ax_next  = x_below ? center_x_reg - sample_x : sample_x - center_x_reg;
            ay_next  = y_below ? center_y_reg - sample_y : sample_y - center_y_reg;
        end

        if (finish)
        begin
            joy_x_next     = sx_hold_reg[jpt_pkg::OUT_W-1:0];
            joy_y_next     = sy_hold_reg[jpt_pkg::OUT_W-1:0];
            sla_next       = sa_hold_reg[jpt_pkg::OUT_W-1:0];
            slb_next       = sb_hold_reg[jpt_pkg::OUT_W-1:0];
            xmin_out_next  = x_min_reg[jpt_pkg::OUT_W-1:0];
            xmax_out_next  = x_max_reg[jpt_pkg::OUT_W-1:0];
            ymin_out_next  = y_min_reg[jpt_pkg::OUT_W-1:0];
            ymax_out_next  = y_max_reg[jpt_pkg::OUT_W-1:0];
            angle_next     = cordic_angle;
            dist_next      = sqrt_root[jpt_pkg::DIST_W-1:0];
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= jpt_pkg::ST_IDLE;
            center_x_reg  <= SAMPLE_BITS'(jpt_pkg::CENTRE_RESET);
            center_y_reg  <= SAMPLE_BITS'(jpt_pkg::CENTRE_RESET);
            x_min_reg     <= '1;
            x_max_reg     <= '0;
            y_min_reg     <= '1;
            y_max_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            center_x_reg  <= center_x_next;
            center_y_reg  <= center_y_next;
            x_min_reg     <= x_min_next;
            x_max_reg     <= x_max_next;
            y_min_reg     <= y_min_next;
            y_max_reg     <= y_max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_hold_reg  <= sx_hold_next;
        sy_hold_reg  <= sy_hold_next;
        sa_hold_reg  <= sa_hold_next;
        sb_hold_reg  <= sb_hold_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        dxn_reg      <= dxn_next;
        dyn_reg      <= dyn_next;
        joy_x_reg    <= joy_x_next;
        joy_y_reg    <= joy_y_next;
        sla_reg      <= sla_next;
        slb_reg      <= slb_next;
        xmin_out_reg <= xmin_out_next;
        xmax_out_reg <= xmax_out_next;
        ymin_out_reg <= ymin_out_next;
        ymax_out_reg <= ymax_out_next;
        angle_reg    <= angle_next;
        dist_reg     <= dist_next;
    end

    assign out_valid    = out_valid_reg;
    assign joy_x        = joy_x_reg;
    assign joy_y        = joy_y_reg;
    assign slider_a_out = sla_reg;
    assign slider_b_out = slb_reg;
    assign x_min        = xmin_out_reg;
    assign x_max        = xmax_out_reg;
    assign y_min        = ymin_out_reg;
    assign y_max        = ymax_out_reg;
    assign angle_deg    = angle_reg;
    assign distance     = dist_reg;

endmodule

`default_nettype wire
